// ===== sv/awn_pkg.sv =====
package awn_pkg;

  // Default frame store geometry
  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 256;

  // Field widths
  localparam int PosW   = 8;
  localparam int PixW   = 8;
  localparam int CoefW  = 18;
  localparam int ShiftW = 9;
  localparam int SizeW  = 9;
  localparam int FracW  = 12;

  // Word opcodes (tuser on the input side)
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam int RegIdxW = 3;
  localparam logic [RegIdxW-1:0] REG_COEF_A  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_COEF_B  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_COEF_C  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_COEF_D  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_SHIFT_X = 3'd4;
  localparam logic [RegIdxW-1:0] REG_SHIFT_Y = 3'd5;
  localparam logic [RegIdxW-1:0] REG_COLS    = 3'd6;
  localparam logic [RegIdxW-1:0] REG_ROWS    = 3'd7;

  // Reset values: identity transform, full 256 x 256 frame
  localparam logic signed [CoefW-1:0] COEF_ONE   = 18'sd4096;
  localparam logic [SizeW-1:0]        SIZE_RESET = 9'd256;

endpackage

// ===== sv/affine_warp_nearest_pixel.sv =====
// Affine warp with inverse mapping and nearest-pixel fetch from an internal
// source frame store.
// Input stream (s_*): each word is a load (tuser = 0) that writes pixel_in at
// (pos_x, pos_y) of the source frame, or a query (tuser = 1) that maps the
// destination pixel (pos_x, pos_y) back through the Q5.12 inverse matrix and
// translation, truncates toward zero and fetches that source pixel.
// Output stream (m_*): one word per query, none per load; tuser is the inside
// flag, tdata the fetched pixel, or zero when the position falls outside.
// Configuration: write cfg_data to register cfg_index while cfg_we is high;
// change it only while the pipeline is empty.
// Throughput: one word per cycle while the receiver does not stall. A query
// result reaches m_tvalid through the input register, product register, address
// register, then the frame store read register, which is the output stage.
// Loads write the store at the same stage where queries read it, so every
// query sees exactly the loads accepted before it.
// When the receiver stalls, the whole pipeline holds and s_tready drops.
// Reset clears the pipeline valids and restores the identity transform and
// a 256 x 256 frame; the frame store itself needs no clearing pass.
module affine_warp_nearest_pixel #(
  parameter int MAX_COLS = awn_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = awn_pkg::MAX_ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [awn_pkg::RegIdxW-1:0]         cfg_index,
  input  logic [awn_pkg::CoefW-1:0]           cfg_data,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [23:0]                         s_tdata,   // pos_x, pos_y, pixel_in
  input  logic                                s_tuser,   // opcode
  // output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [7:0]                          m_tdata,   // pixel_out
  output logic                                m_tuser    // inside_res
);

  localparam int ColW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RowW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AddrW  = ColW + RowW;
  localparam int Depth  = 1 << AddrW;
  localparam int DeltaW = awn_pkg::PosW + 2;
  localparam int ProdW  = awn_pkg::CoefW + DeltaW;
  localparam int SumW   = ProdW + 1;
  localparam int CoordW = SumW - awn_pkg::FracW;

  // Configuration registers
  logic signed [awn_pkg::CoefW-1:0]  coef_a, coef_b, coef_c, coef_d;
  logic signed [awn_pkg::ShiftW-1:0] shift_x, shift_y;
  logic [awn_pkg::SizeW-1:0]         frame_cols, frame_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a     <= awn_pkg::COEF_ONE;
      coef_b     <= '0;
      coef_c     <= '0;
      coef_d     <= awn_pkg::COEF_ONE;
      shift_x    <= '0;
      shift_y    <= '0;
      frame_cols <= awn_pkg::SIZE_RESET;
      frame_rows <= awn_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        awn_pkg::REG_COEF_A:  coef_a     <= cfg_data;
        awn_pkg::REG_COEF_B:  coef_b     <= cfg_data;
        awn_pkg::REG_COEF_C:  coef_c     <= cfg_data;
        awn_pkg::REG_COEF_D:  coef_d     <= cfg_data;
        awn_pkg::REG_SHIFT_X: shift_x    <= cfg_data[awn_pkg::ShiftW-1:0];
        awn_pkg::REG_SHIFT_Y: shift_y    <= cfg_data[awn_pkg::ShiftW-1:0];
        awn_pkg::REG_COLS:    frame_cols <= cfg_data[awn_pkg::SizeW-1:0];
        awn_pkg::REG_ROWS:    frame_rows <= cfg_data[awn_pkg::SizeW-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: limit to what the store holds
  logic [awn_pkg::SizeW-1:0] eff_cols, eff_rows;
  assign eff_cols = (int'(frame_cols) > MAX_COLS) ? awn_pkg::SizeW'(MAX_COLS) : frame_cols;
  assign eff_rows = (int'(frame_rows) > MAX_ROWS) ? awn_pkg::SizeW'(MAX_ROWS) : frame_rows;

  // Global advance: every stage moves unless the output word is stalled
  logic adv;
  logic out_valid;
  assign adv      = !out_valid || m_tready;
  assign s_tready = adv;

  // Stage 1: input register
  logic                     s1_valid, s1_op;
  logic [awn_pkg::PosW-1:0] s1_x, s1_y;
  logic [awn_pkg::PixW-1:0] s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid;
    end
    if (adv) begin
      s1_op  <= s_tuser;
      s1_x   <= s_tdata[7:0];
      s1_y   <= s_tdata[15:8];
      s1_pix <= s_tdata[23:16];
    end
  end

  // Translate, then the four coefficient products
  logic signed [DeltaW-1:0] dx, dy;
  logic signed [ProdW-1:0]  prod_ax, prod_by, prod_cx, prod_dy;
  assign dx      = $signed({2'b00, s1_x}) - DeltaW'(shift_x);
  assign dy      = $signed({2'b00, s1_y}) - DeltaW'(shift_y);
  assign prod_ax = coef_a * dx;
  assign prod_by = coef_b * dy;
  assign prod_cx = coef_c * dx;
  assign prod_dy = coef_d * dy;

  // Stage 2: product register
  logic                     s2_valid, s2_op;
  logic [awn_pkg::PosW-1:0] s2_x, s2_y;
  logic [awn_pkg::PixW-1:0] s2_pix;
  logic signed [ProdW-1:0]  p_ax, p_by, p_cx, p_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
    if (adv) begin
      s2_op  <= s1_op;
      s2_x   <= s1_x;
      s2_y   <= s1_y;
      s2_pix <= s1_pix;
      p_ax   <= prod_ax;
      p_by   <= prod_by;
      p_cx   <= prod_cx;
      p_dy   <= prod_dy;
    end
  end

  // Sum, truncate toward zero (bias negatives before the arithmetic shift)
  logic signed [SumW-1:0]   sum_x, sum_y, bias_x, bias_y;
  logic signed [CoordW-1:0] src_x, src_y;
  logic                     in_x, in_y, load_ok;
  logic [AddrW-1:0]         addr_next;

  assign sum_x  = SumW'(p_ax) + SumW'(p_by);
  assign sum_y  = SumW'(p_cx) + SumW'(p_dy);
  assign bias_x = sum_x + (sum_x[SumW-1] ? SumW'((1 << awn_pkg::FracW) - 1) : SumW'(0));
  assign bias_y = sum_y + (sum_y[SumW-1] ? SumW'((1 << awn_pkg::FracW) - 1) : SumW'(0));
  assign src_x  = bias_x[SumW-1:awn_pkg::FracW];
  assign src_y  = bias_y[SumW-1:awn_pkg::FracW];

  assign in_x = !src_x[CoordW-1] && (src_x < $signed(CoordW'(eff_cols)));
  assign in_y = !src_y[CoordW-1] && (src_y < $signed(CoordW'(eff_rows)));

  // Drop loads outside the effective frame
  assign load_ok = ({1'b0, s2_x} < eff_cols) && ({1'b0, s2_y} < eff_rows);

  assign addr_next = (s2_op == awn_pkg::OP_LOAD) ? {RowW'(s2_y), ColW'(s2_x)}
                                                 : {RowW'(src_y), ColW'(src_x)};

  // Stage 3: address register
  logic                     s3_valid, s3_op, s3_wr, s3_inside;
  logic [AddrW-1:0]         s3_addr;
  logic [awn_pkg::PixW-1:0] s3_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
    if (adv) begin
      s3_op     <= s2_op;
      s3_wr     <= (s2_op == awn_pkg::OP_LOAD) && load_ok;
      s3_inside <= (s2_op == awn_pkg::OP_QUERY) && in_x && in_y;
      s3_addr   <= addr_next;
      s3_pix    <= s2_pix;
    end
  end

  // Frame store: one access per cycle, load writes or query reads
  logic [awn_pkg::PixW-1:0] frame_mem [Depth];
  logic [awn_pkg::PixW-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s3_valid && s3_wr) begin
        frame_mem[s3_addr] <= s3_pix;
      end
      rd_data <= frame_mem[s3_addr];
    end
  end

  // Stage 4: output word
  logic out_inside;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s3_valid && (s3_op == awn_pkg::OP_QUERY);
    end
    if (adv) begin
      out_inside <= s3_inside;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_inside;
  assign m_tdata  = out_inside ? rd_data : '0;

  // Assertions
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("outside query returned a nonzero pixel");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(s3_valid) && $stable(s3_addr) && $stable(s3_wr)))
    else $error("address stage moved during an output stall");

  a_load_not_inside: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_op == awn_pkg::OP_LOAD) |-> (!s3_inside && !$past(1'b0)))
    else $error("load word flagged inside");

  a_query_emits: assert property (@(posedge clk) disable iff (rst)
    (adv && s3_valid && s3_op == awn_pkg::OP_QUERY) |=> m_tvalid)
    else $error("query lost between address stage and output");

endmodule

// ===== tb/sv/affine_warp_nearest_pixel_tb.sv =====
`timescale 1ns / 100ps

module affine_warp_nearest_pixel_tb;

  // Cycles with no word accepted on either side before the run is abandoned
  localparam int STALL_LIMIT = 1000;
  // Pipeline depth is three stages past the accept edge; allow a margin
  localparam int SETTLE_CYCLES = 6;
  localparam int NCOLS = awn_pkg::MAX_COLS_DEF;
  localparam int NROWS = awn_pkg::MAX_ROWS_DEF;

  typedef struct packed {
    logic                     op;
    logic [awn_pkg::PosW-1:0] x;
    logic [awn_pkg::PosW-1:0] y;
    logic [awn_pkg::PixW-1:0] pix;
  } pixel_word_t;

  typedef struct packed {
    logic [awn_pkg::PixW-1:0] pix;
    logic                     in_frame;
  } warp_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          cfg_we    = 1'b0;
  logic [awn_pkg::RegIdxW-1:0]   cfg_index = '0;
  logic [awn_pkg::CoefW-1:0]     cfg_data  = '0;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [23:0]          s_tdata  = '0;  // pos_x, pos_y, pixel_in
  logic                 s_tuser  = 1'b0; // opcode
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;         // pixel_out
  logic                 m_tuser;         // inside_res

  affine_warp_nearest_pixel uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the transform registers, kept in step with every write
  longint          k_a = 4096, k_b = 0, k_c = 0, k_d = 4096;
  longint          k_sx = 0, k_sy = 0;
  logic [awn_pkg::SizeW-1:0] cols_r = awn_pkg::SIZE_RESET, rows_r = awn_pkg::SIZE_RESET;

  // Predicted frame store, filled as loads are accepted
  logic [awn_pkg::PixW-1:0] frame_mem [NCOLS*NROWS];
  // Which pixels the stimulus has already loaded; keeps every query on written pixels
  bit              loaded    [NCOLS*NROWS];

  pixel_word_t   input_words_q[$];
  warp_result_t  expected_pixels_q[$];

  int issued       = 0;
  int fail_count   = 0;
  int src_odds     = 4;
  int snk_odds     = 4;
  int src_gap      = 0;
  int snk_gap      = 0;
  int stall_cycles = 0;
  pixel_word_t  next_word;
  warp_result_t want;

  function automatic int eff_cols();
    return (cols_r > NCOLS) ? NCOLS : int'(cols_r);
  endfunction

  function automatic int eff_rows();
    return (rows_r > NROWS) ? NROWS : int'(rows_r);
  endfunction

  // Drop the fraction, rounding toward zero so that -0.x lands on 0
  function automatic longint trunc_frac(longint v);
    if (v >= 0) return v >>> awn_pkg::FracW;
    return -((-v) >>> awn_pkg::FracW);
  endfunction

  // Map a destination pixel back to the source; returns the in-frame flag
  function automatic logic map_to_source(logic [awn_pkg::PosW-1:0] x,
                                         logic [awn_pkg::PosW-1:0] y,
                                         output int sx, output int sy);
    longint dx, dy;
    dx = x;
    dy = y;
    dx = dx - k_sx;
    dy = dy - k_sy;
    sx = int'(trunc_frac(k_a * dx + k_b * dy));
    sy = int'(trunc_frac(k_c * dx + k_d * dy));
    return sx >= 0 && sy >= 0 && sx < eff_cols() && sy < eff_rows();
  endfunction

  // Apply one accepted word: store a load, or queue the pixel a query fetches
  function automatic void warp_step(logic op, logic [23:0] d);
    logic [awn_pkg::PosW-1:0] x, y;
    logic [awn_pkg::PixW-1:0] v;
    int              sx, sy;
    warp_result_t    r;
    x = d[7:0];
    y = d[15:8];
    v = d[23:16];
    if (op == awn_pkg::OP_LOAD) begin
      if (x < eff_cols() && y < eff_rows()) frame_mem[y * NCOLS + x] = v;
    end else begin
      r.in_frame = map_to_source(x, y, sx, sy);
      r.pix      = r.in_frame ? frame_mem[sy * NCOLS + sx] : '0;
      expected_pixels_q.push_back(r);
    end
  endfunction

  // Queue a load; only loads that land inside the frame count as work
  task automatic push_load(int x, int y, int v);
    pixel_word_t w;
    w.op  = awn_pkg::OP_LOAD;
    w.x   = awn_pkg::PosW'(x);
    w.y   = awn_pkg::PosW'(y);
    w.pix = awn_pkg::PixW'(v);
    input_words_q.push_back(w);
    if (x < eff_cols() && y < eff_rows()) begin
      loaded[y * NCOLS + x] = 1'b1;
      issued++;
    end
  endtask

  // Queue a query, loading its source pixel first if it was never written
  task automatic push_query(int x, int y);
    pixel_word_t w;
    int          sx, sy;
    if (map_to_source(awn_pkg::PosW'(x), awn_pkg::PosW'(y), sx, sy) &&
        !loaded[sy * NCOLS + sx])
      push_load(sx, sy, $urandom_range(0, 255));
    w.op  = awn_pkg::OP_QUERY;
    w.x   = awn_pkg::PosW'(x);
    w.y   = awn_pkg::PosW'(y);
    w.pix = awn_pkg::PixW'($urandom_range(0, 255));  // ignored by the block on a query
    input_words_q.push_back(w);
    issued++;
  endtask

  task automatic write_reg(logic [awn_pkg::RegIdxW-1:0] idx, int val);
    logic [awn_pkg::CoefW-1:0] word;
    word = awn_pkg::CoefW'(val);
    if (idx >= awn_pkg::REG_SHIFT_X)
      word = {{(awn_pkg::CoefW-awn_pkg::SizeW){1'b0}}, word[awn_pkg::SizeW-1:0]};
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    case (idx)
      awn_pkg::REG_COEF_A:  k_a    = longint'($signed(word));
      awn_pkg::REG_COEF_B:  k_b    = longint'($signed(word));
      awn_pkg::REG_COEF_C:  k_c    = longint'($signed(word));
      awn_pkg::REG_COEF_D:  k_d    = longint'($signed(word));
      awn_pkg::REG_SHIFT_X: k_sx   = longint'($signed(word[awn_pkg::ShiftW-1:0]));
      awn_pkg::REG_SHIFT_Y: k_sy   = longint'($signed(word[awn_pkg::ShiftW-1:0]));
      awn_pkg::REG_COLS:    cols_r = word[awn_pkg::SizeW-1:0];
      awn_pkg::REG_ROWS:    rows_r = word[awn_pkg::SizeW-1:0];
      default: ;
    endcase
  endtask

  // Rewrite every register; only called with the pipeline empty
  task automatic set_config(int a, int b, int c, int d, int shx, int shy,
                            int ncols, int nrows);
    write_reg(awn_pkg::REG_COEF_A, a);
    write_reg(awn_pkg::REG_COEF_B, b);
    write_reg(awn_pkg::REG_COEF_C, c);
    write_reg(awn_pkg::REG_COEF_D, d);
    write_reg(awn_pkg::REG_SHIFT_X, shx);
    write_reg(awn_pkg::REG_SHIFT_Y, shy);
    write_reg(awn_pkg::REG_COLS, ncols);
    write_reg(awn_pkg::REG_ROWS, nrows);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every word is sent and every result is back, then let loads retire
  task automatic drain_pipe();
    do @(negedge clk);
    while (input_words_q.size() != 0 || s_tvalid || expected_pixels_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Frame sizes: mostly legal, sometimes zero, one, full, or past the store
  function automatic int pick_size();
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return $urandom_range(257, 511);
      2:       return NCOLS;
      3:       return 1;
      default: return $urandom_range(1, 256);
    endcase
  endfunction

  // kind 0: mild rotation/scale, kind 1: anything, kind 2: corner values
  function automatic int pick_coef(int kind, bit diag);
    if (kind == 0) begin
      if (diag) return $urandom_range(2048, 6144);
      return int'($urandom_range(0, 2048)) - 1024;
    end
    if (kind == 1) return int'($urandom_range(0, 262143)) - 131072;
    case ($urandom_range(0, 6))
      0:       return -131072;
      1:       return 131071;
      2:       return 0;
      3:       return 4096;
      4:       return -4096;
      5:       return -1;
      default: return 1;
    endcase
  endfunction

  // Driver: present the next pending word, hold it until accepted,
  // and insert idle bursts between words
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) warp_step(s_tuser, s_tdata);
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (input_words_q.size() > 0 && src_odds != 0 &&
                     $urandom_range(1, src_odds) == 1) begin
          src_gap = $urandom_range(0, 12);
          s_tvalid <= 1'b0;
        end else if (input_words_q.size() > 0) begin
          next_word = input_words_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= next_word.op;
          s_tdata  <= {next_word.pix, next_word.y, next_word.x};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction,
  // and stall the output in random bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_pixels_q.size() == 0) begin
          $display("%0t: expected no word, got pixel %0d inside %0b",
                   $time, m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = expected_pixels_q.pop_front();
          if (m_tdata !== want.pix) begin
            $display("%0t: pixel_out expected %0d, got %0d", $time, want.pix, m_tdata);
            fail_count++;
          end
          if (m_tuser !== want.in_frame) begin
            $display("%0t: inside_res expected %0b, got %0b", $time, want.in_frame, m_tuser);
            fail_count++;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 1'b0;
      end else if (snk_odds != 0 && $urandom_range(1, snk_odds) == 1) begin
        snk_gap = $urandom_range(0, 12);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: give up when nothing moves on either side for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int phase, kind, target, ec, er;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset transform: corners of the full frame at both pixel extremes
    push_load(0, 0, 255);
    push_load(255, 255, 0);
    push_load(255, 0, 8'h5A);
    push_load(0, 255, 8'hA5);
    push_query(0, 0);
    push_query(255, 255);
    push_query(255, 0);
    push_query(0, 255);
    drain_pipe();

    // Tiny frame: loads past the edge are dropped, queries past it fall outside
    set_config(4096, 0, 0, 4096, 0, 0, 4, 3);
    push_load(4, 0, 7);
    push_load(0, 3, 9);
    push_load(3, 2, 8'h77);
    push_query(4, 0);
    push_query(0, 3);
    push_query(3, 2);
    push_query(255, 255);
    drain_pipe();

    // Zero size: everything is outside and loads are dropped
    set_config(4096, 0, 0, 4096, 0, 0, 0, 0);
    push_query(0, 0);
    push_load(0, 0, 8'h11);
    push_query(0, 0);
    drain_pipe();

    // Oversized frame clamps to the store; -0.999 truncates to 0, -1.99 to -1
    set_config(-4095, 0, 0, 4096, 0, 0, 511, 300);
    push_query(1, 7);
    push_query(2, 7);
    drain_pipe();

    // Coefficient and shift extremes
    set_config(-131072, 131071, 131071, -131072, 255, -256, 256, 256);
    push_query(255, 0);
    push_query(0, 255);
    push_query(128, 128);
    drain_pipe();

    for (phase = 0; phase < 10; phase++) begin
      kind = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 2);
      set_config(pick_coef(kind, 1'b1), pick_coef(kind, 1'b0),
                 pick_coef(kind, 1'b0), pick_coef(kind, 1'b1),
                 (kind == 0) ? int'($urandom_range(0, 64)) - 32
                             : int'($urandom_range(0, 511)) - 256,
                 (kind == 0) ? int'($urandom_range(0, 64)) - 32
                             : int'($urandom_range(0, 511)) - 256,
                 pick_size(), pick_size());
      // Quiet tail; otherwise vary how often each side idles, sometimes never
      if (phase >= 8) begin
        src_odds = 0;
        snk_odds = 0;
      end else begin
        src_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 10);
        snk_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 10);
      end
      ec = eff_cols();
      er = eff_rows();
      target = issued + 103;
      while (issued < target) begin
        if ($urandom_range(0, 99) < 35) begin
          if (ec > 0 && er > 0 && $urandom_range(0, 7) != 0)
            push_load($urandom_range(0, ec - 1), $urandom_range(0, er - 1),
                      $urandom_range(0, 255));
          else
            push_load($urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255));
        end else begin
          push_query($urandom_range(0, 255), $urandom_range(0, 255));
        end
      end
      drain_pipe();
    end

    if (fail_count == 0 && expected_pixels_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
